@@ rtl/x64s_pkg.sv @@
// Package for the xorshift64* range generator.
// Holds the request kinds, the generator and mixer constants and small helper functions.
// No dependencies.
package x64s_pkg;

  typedef enum logic [2:0] {
    OP_S16  = 3'd0,
    OP_U16  = 3'd1,
    OP_S32  = 3'd2,
    OP_U32  = 3'd3,
    OP_S64  = 3'd4,
    OP_U64  = 3'd5,
    OP_FRAC = 3'd6
  } op_e;

  localparam logic [63:0] DefaultSeed = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] OutMult     = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] MixA        = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MixB        = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned CntW     = 6;
  localparam int unsigned MulSteps = 32;
  localparam int unsigned DivSteps = 64;
  localparam logic [CntW-1:0] MulLast = CntW'(MulSteps - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);

  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

  function automatic logic [63:0] fmt(input logic [63:0] v, input op_e op);
    logic [63:0] r;
    case (op)
      OP_S16:  r = {{48{v[15]}}, v[15:0]};
      OP_U16:  r = {48'd0, v[15:0]};
      OP_S32:  r = {{32{v[31]}}, v[31:0]};
      OP_U32:  r = {32'd0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/xorshift64star_range_generator.sv @@
// Top level of the xorshift64* range generator with a seed mixer.
// Uses x64s_pkg; one shared 2-bit-per-cycle multiplier and a 1-bit-per-cycle restoring divider.
// An item passes the range check and the multiplier, and a ranged integer draw also the divider,
// before the output stage; a new item is taken only once the last has gone to the output register.
// An empty range or an unused kind goes from the range check straight to the output stage.
// The multiplier takes 32 steps and the divider 64 steps.
// A seed write keeps the input stalled while the mixer runs.
// Reset loads the default seed constant without mixing and empties the output register.
module xorshift64star_range_generator
  import x64s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic        ranged_i,
  input  logic [63:0] range_low_i,
  input  logic [63:0] range_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_SEED_A,
    ST_SEED_B
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     gen_q, gen_d;
  logic [63:0]     mcand_q, mcand_d;
  logic [63:0]     mplier_q, mplier_d;
  logic [63:0]     acc_q, acc_d;
  logic [63:0]     dvd_q, dvd_d;
  logic [63:0]     rem_q, rem_d;
  logic [64:0]     div_m_q, div_m_d;
  op_e             op_q, op_d;
  logic            ranged_q, ranged_d;
  logic [63:0]     a_q, a_d;
  logic [63:0]     b_q, b_d;
  logic [63:0]     res_q, res_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     value_q, value_d;

  logic        in_acc;
  logic        is_signed;
  logic        is_16;
  logic [63:0] flip;
  logic [63:0] ua;
  logic [63:0] ub;
  logic        range_empty;
  logic [64:0] span;
  logic [63:0] mul_sum;
  logic [64:0] div_sh;
  logic        div_ge;
  logic [63:0] div_rem;
  logic [63:0] seed_z;
  logic [63:0] seed_out;

  assign in_stall_o = (state_q != ST_IDLE) || cfg_we_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_signed   = (op_q == OP_S16) || (op_q == OP_S32) || (op_q == OP_S64);
  assign is_16       = (op_q == OP_S16) || (op_q == OP_U16);
  assign flip        = {is_signed, 63'd0};
  assign ua          = a_q ^ flip;
  assign ub          = b_q ^ flip;
  assign range_empty = ua >= ub;
  assign span        = {1'b0, ub} - {1'b0, ua} + 65'd1;

  assign mul_sum = acc_q + (mplier_q[0] ? mcand_q : 64'd0)
                 + (mplier_q[1] ? {mcand_q[62:0], 1'b0} : 64'd0);

  assign div_sh  = {rem_q, dvd_q[63]};
  assign div_ge  = div_sh >= div_m_q;
  assign div_rem = div_ge ? 64'(div_sh - div_m_q) : div_sh[63:0];

  assign seed_z   = cfg_wdata_i + DefaultSeed;
  assign seed_out = mul_sum ^ (mul_sum >> 31);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gen_d       = gen_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_m_d     = div_m_q;
    op_d        = op_q;
    ranged_d    = ranged_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (state_q == ST_MUL || state_q == ST_SEED_A || state_q == ST_SEED_B) begin
      acc_d    = mul_sum;
      mcand_d  = {mcand_q[61:0], 2'b00};
      mplier_d = {2'b00, mplier_q[63:2]};
      cnt_d    = cnt_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          mcand_d  = seed_z ^ (seed_z >> 30);
          mplier_d = MixA;
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = ST_SEED_A;
        end else if (in_acc) begin
          op_d     = op_e'(operation_i);
          ranged_d = ranged_i;
          a_d      = fmt(range_low_i, op_e'(operation_i));
          b_d      = fmt(range_high_i, op_e'(operation_i));
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        div_m_d = span;
        if (op_q > OP_FRAC) begin
          res_d   = '0;
          state_d = ST_FIN;
        end else if (ranged_q && op_q != OP_FRAC && range_empty) begin
          res_d   = a_q;
          state_d = ST_FIN;
        end else begin
          gen_d    = xorshift(gen_q);
          mcand_d  = xorshift(gen_q);
          mplier_d = OutMult;
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == MulLast) begin
          if (op_q == OP_FRAC) begin
            res_d   = {40'd0, mul_sum[63:40]};
            state_d = ST_FIN;
          end else if (!ranged_q) begin
            res_d   = fmt(mul_sum, op_q);
            state_d = ST_FIN;
          end else begin
            dvd_d   = is_16 ? {32'd0, mul_sum[31:0]} : mul_sum;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = div_rem;
        dvd_d = {dvd_q[62:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          res_d   = fmt(a_q + div_rem, op_q);
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          value_d     = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_SEED_A: begin
        if (cnt_q == MulLast) begin
          mcand_d  = mul_sum ^ (mul_sum >> 27);
          mplier_d = MixB;
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = ST_SEED_B;
        end
      end
      ST_SEED_B: begin
        if (cnt_q == MulLast) begin
          gen_d   = (seed_out == '0) ? DefaultSeed : seed_out;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      gen_q       <= DefaultSeed;
      mcand_q     <= '0;
      mplier_q    <= '0;
      acc_q       <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      div_m_q     <= 65'd2;
      op_q        <= OP_S16;
      ranged_q    <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      mcand_q     <= mcand_d;
      mplier_q    <= mplier_d;
      acc_q       <= acc_d;
      dvd_q       <= dvd_d;
      rem_q       <= rem_d;
      div_m_q     <= div_m_d;
      op_q        <= op_d;
      ranged_q    <= ranged_d;
      a_q         <= a_d;
      b_q         <= b_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      value_q     <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  // The generator state can never collapse to zero.
  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0)
    else $error("generator state is zero");

  // An accepted item always goes to the range check next.
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_CHECK)
    else $error("accepted item did not reach the range check");

  // The divisor during a ranged draw spans at least two values.
  a_div_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_m_q >= 65'd2)
    else $error("divisor below two");

  // The multiplier only hands over to the divider or the output stage.
  a_mul_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> state_q == ST_MUL || state_q == ST_DIV || state_q == ST_FIN)
    else $error("bad state after multiply");

  // A result is only loaded into a free or draining output register.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && out_valid_q && out_stall_i |=> state_q == ST_FIN)
    else $error("result overwrote a stalled item");

endmodule
